>>> rtl/gcls_pkg.sv
// ----------------------------------------------------------------------------
// Grid corner line-of-sight package
// Shared sizes, register indexes, operation codes and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package gcls_pkg;

  // Physical size of the cost store.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  // Field widths.
  localparam int COORD_W    = 8;
  localparam int COST_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int DIM_CFG_W  = 9;

  // A checked cell may sit one past the last coordinate.
  localparam int CELL_W = COORD_W + 1;

  // Cost store depth and address width.
  localparam int RAM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);

  // Width that holds a grid dimension, a clamp limit and a cell coordinate.
  localparam int DIM_MAX_W = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                             $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
  localparam int DIM_W     = (DIM_MAX_W > DIM_CFG_W) ? DIM_MAX_W : DIM_CFG_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_THRESHOLD = CFG_IDX_W'(2);

  // Configuration reset values.
  localparam logic [DIM_CFG_W-1:0] GRID_WIDTH_RST      = DIM_CFG_W'(256);
  localparam logic [DIM_CFG_W-1:0] GRID_HEIGHT_RST     = DIM_CFG_W'(256);
  localparam logic [COST_W-1:0]    BLOCK_THRESHOLD_RST = COST_W'(253);

  // Request operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;     // capture a query and set up the walk
    logic wr;       // store the request's cost in the grid
    logic issue_a;  // read the first cell of a step and advance the walk
    logic issue_b;  // read the second cell of the step
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic at_end;   // major coordinate has reached the end cell
    logic blocked;  // some checked cell blocked sight
  } status_t;

endpackage

>>> rtl/gcls_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gcls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/gcls_ctrl.sv
// ----------------------------------------------------------------------------
// Grid corner line-of-sight controller
// Sequences each query through its walk steps and owns the result register.
// ----------------------------------------------------------------------------
module gcls_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_operation,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_visible,
  output gcls_pkg::cmd_t    cmd,
  input  gcls_pkg::status_t status
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHK    = 3'd1;
  localparam logic [2:0] ST_WALK_A = 3'd2;
  localparam logic [2:0] ST_WALK_B = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_visible_r, out_visible_nxt;

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

  // Next state, commands and result register.
  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    out_valid_nxt   = out_valid_r & ~out_ready;
    out_visible_nxt = out_visible_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_operation == gcls_pkg::OP_QUERY) begin
            cmd.load  = 1'b1;
            state_nxt = ST_CHK;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_CHK: begin
        // A query whose start and end share the major coordinate has no steps.
        state_nxt = status.at_end ? ST_DONE : ST_WALK_A;
      end
      ST_WALK_A: begin
        cmd.issue_a = 1'b1;
        state_nxt   = ST_WALK_B;
      end
      ST_WALK_B: begin
        cmd.issue_b = 1'b1;
        state_nxt   = status.at_end ? ST_FIN : ST_WALK_A;
      end
      ST_FIN: begin
        // The last cell read is judged during this cycle.
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_visible_nxt = ~status.blocked;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_visible_r <= out_visible_nxt;
  end

endmodule

>>> rtl/gcls_dp.sv
// ----------------------------------------------------------------------------
// Grid corner line-of-sight datapath
// Holds the configuration, the walk state along the major axis and the
// error accumulator, forms the cost store addresses and judges each cell.
// ----------------------------------------------------------------------------
module gcls_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [gcls_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gcls_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [gcls_pkg::COORD_W-1:0]        in_start_x,
  input  logic [gcls_pkg::COORD_W-1:0]        in_start_y,
  input  logic [gcls_pkg::COORD_W-1:0]        in_end_x,
  input  logic [gcls_pkg::COORD_W-1:0]        in_end_y,
  input  logic [gcls_pkg::COST_W-1:0]         in_cell_cost,
  input  gcls_pkg::cmd_t                      cmd,
  output gcls_pkg::status_t                   status,
  output logic                                ram_we,
  output logic [gcls_pkg::ADDR_W-1:0]         ram_waddr,
  output logic [gcls_pkg::COST_W-1:0]         ram_wdata,
  output logic [gcls_pkg::ADDR_W-1:0]         ram_raddr,
  input  logic [gcls_pkg::COST_W-1:0]         ram_rdata
);

  localparam int CW  = gcls_pkg::COORD_W;
  localparam int EW  = gcls_pkg::CELL_W;
  localparam int DW  = gcls_pkg::DIM_W;
  localparam int AW  = gcls_pkg::ADDR_W;

  // Linear address of a cell inside the store.
  function automatic logic [AW-1:0] cell_addr(input logic [EW-1:0] cx,
                                              input logic [EW-1:0] cy);
    return AW'(cy) * AW'(gcls_pkg::MAX_WIDTH) + AW'(cx);
  endfunction

  // Configuration registers.
  logic [gcls_pkg::DIM_CFG_W-1:0] grid_w_r, grid_h_r;
  logic [gcls_pkg::COST_W-1:0]    thr_r;

  // Walk state.
  logic [CW-1:0] maj_r, maj_end_r, min_r, dmaj_r, dmin_r, k_r;
  logic          neg_maj_r, neg_min_r, swap_r;
  logic [CW-1:0] maj_nxt, maj_end_nxt, min_nxt, dmaj_nxt, dmin_nxt, k_nxt;
  logic          neg_maj_nxt, neg_min_nxt, swap_nxt;

  // Check pipeline and second-cell holding registers.
  logic          chk_v_r, chk_v_nxt;
  logic          chk_out_r, chk_out_nxt;
  logic          b_need_r, b_need_nxt;
  logic          b_out_r, b_out_nxt;
  logic [AW-1:0] b_addr_r, b_addr_nxt;
  logic          blk_r, blk_nxt;

  // Load-time decode.
  logic          neg_x, neg_y, swap_ld;
  logic [CW-1:0] adx, ady;

  // Step arithmetic.
  logic [CW:0]   ksum;
  logic          diag, straight;
  logic [CW-1:0] knew, minnew, majnew;
  logic [EW-1:0] cmaj, a_min, b_min;
  logic [EW-1:0] ax, ay, bx, by;
  logic          a_need, b_need, a_in, b_in;
  logic [DW-1:0] w_use, h_use;

  // Grid size in use, clamped to the store.
  assign w_use = (DW'(grid_w_r) > DW'(gcls_pkg::MAX_WIDTH))  ? DW'(gcls_pkg::MAX_WIDTH)  :
                                                               DW'(grid_w_r);
  assign h_use = (DW'(grid_h_r) > DW'(gcls_pkg::MAX_HEIGHT)) ? DW'(gcls_pkg::MAX_HEIGHT) :
                                                               DW'(grid_h_r);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= gcls_pkg::GRID_WIDTH_RST;
      grid_h_r <= gcls_pkg::GRID_HEIGHT_RST;
      thr_r    <= gcls_pkg::BLOCK_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gcls_pkg::REG_GRID_WIDTH:      grid_w_r <= cfg_wdata;
        gcls_pkg::REG_GRID_HEIGHT:     grid_h_r <= cfg_wdata;
        gcls_pkg::REG_BLOCK_THRESHOLD: thr_r    <= cfg_wdata[gcls_pkg::COST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Cost writes; coordinates beyond the store are dropped.
  assign ram_we    = cmd.wr && (DW'(in_start_x) < DW'(gcls_pkg::MAX_WIDTH))
                            && (DW'(in_start_y) < DW'(gcls_pkg::MAX_HEIGHT));
  assign ram_waddr = cell_addr(EW'(in_start_x), EW'(in_start_y));
  assign ram_wdata = in_cell_cost;

  // Query decode: absolute deltas, directions and the major axis.
  always_comb begin
    neg_x   = in_end_x < in_start_x;
    neg_y   = in_end_y < in_start_y;
    adx     = neg_x ? (in_start_x - in_end_x) : (in_end_x - in_start_x);
    ady     = neg_y ? (in_start_y - in_end_y) : (in_end_y - in_start_y);
    swap_ld = ady > adx;
  end

  // One step of the error accumulator and the cells it checks.
  always_comb begin
    ksum     = {1'b0, k_r} + {1'b0, dmin_r};
    diag     = ksum >= {1'b0, dmaj_r};
    knew     = diag ? CW'(ksum - {1'b0, dmaj_r}) : CW'(ksum);
    minnew   = diag ? (neg_min_r ? min_r - CW'(1) : min_r + CW'(1)) : min_r;
    majnew   = neg_maj_r ? maj_r - CW'(1) : maj_r + CW'(1);
    straight = dmin_r == '0;
    cmaj     = EW'(maj_r) + EW'(!neg_maj_r);
    // First cell: the corner before a minor move, or one side of a straight line.
    a_need   = diag | straight;
    a_min    = diag ? EW'(min_r) + EW'(!neg_min_r) : EW'(min_r);
    // Second cell: the corner after the step, or the other side of a straight line.
    b_need   = (knew != '0) | straight;
    b_min    = (knew != '0) ? EW'(minnew) + EW'(!neg_min_r) : EW'(min_r) + EW'(1);
    ax       = swap_r ? a_min : cmaj;
    ay       = swap_r ? cmaj  : a_min;
    bx       = swap_r ? b_min : cmaj;
    by       = swap_r ? cmaj  : b_min;
    a_in     = (DW'(ax) < w_use) && (DW'(ay) < h_use);
    b_in     = (DW'(bx) < w_use) && (DW'(by) < h_use);
  end

  assign ram_raddr = cmd.issue_b ? b_addr_r : cell_addr(ax, ay);

  // Walk register updates.
  always_comb begin
    maj_nxt     = maj_r;
    maj_end_nxt = maj_end_r;
    min_nxt     = min_r;
    dmaj_nxt    = dmaj_r;
    dmin_nxt    = dmin_r;
    k_nxt       = k_r;
    neg_maj_nxt = neg_maj_r;
    neg_min_nxt = neg_min_r;
    swap_nxt    = swap_r;
    b_need_nxt  = b_need_r;
    b_out_nxt   = b_out_r;
    b_addr_nxt  = b_addr_r;
    chk_v_nxt   = 1'b0;
    chk_out_nxt = 1'b0;
    if (cmd.load) begin
      swap_nxt    = swap_ld;
      maj_nxt     = swap_ld ? in_start_y : in_start_x;
      maj_end_nxt = swap_ld ? in_end_y   : in_end_x;
      min_nxt     = swap_ld ? in_start_x : in_start_y;
      dmaj_nxt    = swap_ld ? ady : adx;
      dmin_nxt    = swap_ld ? adx : ady;
      neg_maj_nxt = swap_ld ? neg_y : neg_x;
      neg_min_nxt = swap_ld ? neg_x : neg_y;
      k_nxt       = '0;
    end else if (cmd.issue_a) begin
      maj_nxt     = majnew;
      min_nxt     = minnew;
      k_nxt       = knew;
      b_need_nxt  = b_need;
      b_out_nxt   = ~b_in;
      b_addr_nxt  = cell_addr(bx, by);
      chk_v_nxt   = a_need;
      chk_out_nxt = ~a_in;
    end else if (cmd.issue_b) begin
      chk_v_nxt   = b_need_r;
      chk_out_nxt = b_out_r;
    end
  end

  // Judge the cell read in the previous cycle.
  always_comb begin
    blk_nxt = blk_r;
    if (cmd.load) begin
      blk_nxt = 1'b0;
    end else if (chk_v_r && (chk_out_r || (ram_rdata > thr_r))) begin
      blk_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_v_r <= 1'b0;
      blk_r   <= 1'b0;
    end else begin
      chk_v_r <= chk_v_nxt;
      blk_r   <= blk_nxt;
    end
  end

  // Walk payload registers.
  always_ff @(posedge clk) begin
    maj_r     <= maj_nxt;
    maj_end_r <= maj_end_nxt;
    min_r     <= min_nxt;
    dmaj_r    <= dmaj_nxt;
    dmin_r    <= dmin_nxt;
    k_r       <= k_nxt;
    neg_maj_r <= neg_maj_nxt;
    neg_min_r <= neg_min_nxt;
    swap_r    <= swap_nxt;
    b_need_r  <= b_need_nxt;
    b_out_r   <= b_out_nxt;
    b_addr_r  <= b_addr_nxt;
    chk_out_r <= chk_out_nxt;
  end

  assign status.at_end  = maj_r == maj_end_r;
  assign status.blocked = blk_r;

endmodule

>>> rtl/grid_corner_line_of_sight_core.sv
// ----------------------------------------------------------------------------
// Grid corner line-of-sight core
// Cost grid store with a line-of-sight walker between two grid cells.
// ----------------------------------------------------------------------------
// A write request leaves the controller idle, so a new request can follow at once.
// A query of n steps (n = larger of |dx| and |dy|) walks no steps when n is zero;
// otherwise the two cost reads of each step share the single read port of the store.
// The next request is taken the cycle after the result is loaded.
// Reset clears control state and configuration; the cost store is not cleared.
module grid_corner_line_of_sight_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [gcls_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gcls_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [gcls_pkg::COORD_W-1:0]      in_start_x,
  input  logic [gcls_pkg::COORD_W-1:0]      in_start_y,
  input  logic [gcls_pkg::COORD_W-1:0]      in_end_x,
  input  logic [gcls_pkg::COORD_W-1:0]      in_end_y,
  input  logic [gcls_pkg::COST_W-1:0]       in_cell_cost,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_visible
);

  gcls_pkg::cmd_t                cmd;
  gcls_pkg::status_t             status;
  logic                          ram_we;
  logic [gcls_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [gcls_pkg::COST_W-1:0]   ram_wdata, ram_rdata;

  // Sequencer.
  gcls_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_visible  (out_visible),
    .cmd          (cmd),
    .status       (status)
  );

  // Walk datapath.
  gcls_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_start_x   (in_start_x),
    .in_start_y   (in_start_y),
    .in_end_x     (in_end_x),
    .in_end_y     (in_end_y),
    .in_cell_cost (in_cell_cost),
    .cmd          (cmd),
    .status       (status),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  // Cost grid store.
  gcls_ram #(
    .WIDTH (gcls_pkg::COST_W),
    .DEPTH (gcls_pkg::RAM_DEPTH)
  ) u_cost_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The first read of a step is always followed by the second.
  a_step_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue_a |=> cmd.issue_b)
    else $error("walk step did not issue its second read");

  // The store is written only for an accepted write request.
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (in_valid && in_ready && in_operation == gcls_pkg::OP_WRITE))
    else $error("cost store written without a write request");

  // A query in progress blocks new requests.
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_ready)
    else $error("request accepted while a query is being walked");

endmodule
